/* src/sbrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrl_pkg
// Shared types and constants of the token-bucket rate limiter.
// ----------------------------------------------------------------------------
package sbrl_pkg;

  localparam int RateW     = 20;
  localparam int BurstW    = 12;
  localparam int PermitW   = 16;
  localparam int TimeW     = 63;
  localparam int StoreW    = 32;
  localparam int PushW     = PermitW + RateW;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 20;
  localparam int DivSteps  = TimeW;
  localparam int DivCntW   = $clog2(DivSteps + 1);

  localparam logic [RateW-1:0]  MICROS_PER_SECOND = 20'd1000000;
  localparam logic [RateW-1:0]  RATE_MAX          = 20'd1000000;
  localparam logic [BurstW-1:0] BURST_MAX         = 12'd3600;
  localparam logic [TimeW-1:0]  TIME_MAX          = {TimeW{1'b1}};

  localparam logic [CfgIndexW-1:0] REG_RATE  = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_BURST = 2'd1;

  typedef struct packed {
    logic cfg_write;
    logic derive_start;
    logic derive_finish;
    logic item_load;
    logic refuse_load;
    logic refill_start;
    logic refill_finish;
    logic spend;
    logic multiply;
    logic push;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic now_after;
    logic refuse;
    logic div_done;
  } sts_t;

endpackage

/* src/sbrl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrl_div
// Restoring divider, one quotient bit per cycle, 63-bit dividend.
// ----------------------------------------------------------------------------
module sbrl_div
  import sbrl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TimeW-1:0] dividend,
  input  logic [RateW-1:0] divisor,
  output logic             done,
  output logic [TimeW-1:0] quotient
);

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [RateW-1:0]   rem;
  logic [RateW-1:0]   dsr;
  logic [TimeW-1:0]   quo;
  logic [RateW:0]     trial;
  logic               fits;

  assign trial    = {rem, quo[TimeW-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DivCntW'(DivSteps);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DivCntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? RateW'(trial - {1'b0, dsr}) : trial[RateW-1:0];
      quo <= {quo[TimeW-2:0], fits};
    end
  end

endmodule

/* src/sbrl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrl_dp
// Bucket state, configuration registers, refill, spend and push datapath.
// ----------------------------------------------------------------------------
module sbrl_dp
  import sbrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 mode,
  input  logic [PermitW-1:0]   permits,
  input  logic [TimeW-1:0]     now_us,
  output logic                 granted,
  output logic [TimeW-1:0]     wait_us
);

  logic [RateW-1:0]   rate_reg;
  logic [BurstW-1:0]  burst_reg;
  logic [RateW-1:0]   interval;
  logic [StoreW-1:0]  max_permits;
  logic [StoreW-1:0]  stored;
  logic [TimeW-1:0]   nft;
  logic               req_mode;
  logic [PermitW-1:0] req_permits;
  logic [TimeW-1:0]   req_now;
  logic [PermitW-1:0] deficit;
  logic [PushW-1:0]   push;
  logic               res_granted;
  logic [TimeW-1:0]   res_wait;

  logic [RateW-1:0]   rate_cl;
  logic [BurstW-1:0]  burst_cl;
  logic [StoreW-1:0]  burst_prod;
  logic [TimeW-1:0]   div_dividend;
  logic [RateW-1:0]   div_divisor;
  logic               div_done;
  logic [TimeW-1:0]   div_quo;
  logic [TimeW:0]     refill_sum;
  logic [PermitW-1:0] spend_amt;
  logic [TimeW:0]     push_sum;

  always_comb begin
    if (rate_reg == '0) begin
      rate_cl = RateW'(1);
    end else if (rate_reg > RATE_MAX) begin
      rate_cl = RATE_MAX;
    end else begin
      rate_cl = rate_reg;
    end
    if (burst_reg == '0) begin
      burst_cl = BurstW'(1);
    end else if (burst_reg > BURST_MAX) begin
      burst_cl = BURST_MAX;
    end else begin
      burst_cl = burst_reg;
    end
  end

  assign burst_prod   = {{RateW{1'b0}}, burst_cl} * {{BurstW{1'b0}}, rate_cl};
  assign div_dividend = cmd.derive_start ? TimeW'(MICROS_PER_SECOND) : req_now - nft;
  assign div_divisor  = cmd.derive_start ? rate_cl : interval;

  sbrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.derive_start | cmd.refill_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign refill_sum = {{(TimeW + 1 - StoreW){1'b0}}, stored} + {1'b0, div_quo};
  assign spend_amt  = ({{(StoreW - PermitW){1'b0}}, req_permits} < stored) ?
                      req_permits : stored[PermitW-1:0];
  assign push_sum   = {1'b0, nft} + {{(TimeW + 1 - PushW){1'b0}}, push};

  assign sts.now_after = req_now > nft;
  assign sts.refuse    = req_mode && (req_now < nft);
  assign sts.div_done  = div_done;

  // bucket state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg    <= RateW'(1);
      burst_reg   <= BurstW'(1);
      interval    <= MICROS_PER_SECOND;
      max_permits <= StoreW'(1);
      stored      <= '0;
      nft         <= '0;
    end else begin
      if (cmd.cfg_write) begin
        if (cfg_index == REG_RATE) begin
          rate_reg <= cfg_data[RateW-1:0];
        end else if (cfg_index == REG_BURST) begin
          burst_reg <= cfg_data[BurstW-1:0];
        end
      end
      if (cmd.derive_start) begin
        max_permits <= burst_prod;
      end
      if (cmd.derive_finish) begin
        interval <= div_quo[RateW-1:0];
      end
      if (cmd.refill_finish) begin
        stored <= (refill_sum > {{(TimeW + 1 - StoreW){1'b0}}, max_permits}) ?
                  max_permits : refill_sum[StoreW-1:0];
        nft    <= req_now;
      end
      if (cmd.spend) begin
        stored <= stored - {{(StoreW - PermitW){1'b0}}, spend_amt};
      end
      if (cmd.push) begin
        nft <= (push_sum > {1'b0, TIME_MAX}) ? TIME_MAX : push_sum[TimeW-1:0];
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      req_mode    <= mode;
      req_permits <= permits;
      req_now     <= now_us;
    end
    if (cmd.refuse_load) begin
      res_granted <= 1'b0;
      res_wait    <= nft - req_now;
    end
    if (cmd.spend) begin
      deficit     <= req_permits - spend_amt;
      res_granted <= 1'b1;
      res_wait    <= (!req_mode && (nft > req_now)) ? nft - req_now : '0;
    end
    if (cmd.multiply) begin
      push <= {{RateW{1'b0}}, deficit} * {{PermitW{1'b0}}, interval};
    end
    if (cmd.out_load) begin
      granted <= res_granted;
      wait_us <= res_wait;
    end
  end

endmodule

/* src/sbrl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrl_ctrl
// Sequencer for configuration derive and request processing.
// ----------------------------------------------------------------------------
module sbrl_ctrl
  import sbrl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DERIVE     = 4'd1;
  localparam logic [3:0] S_DERIVE_DIV = 4'd2;
  localparam logic [3:0] S_EVAL       = 4'd3;
  localparam logic [3:0] S_DIV        = 4'd4;
  localparam logic [3:0] S_REFILL     = 4'd5;
  localparam logic [3:0] S_SPEND      = 4'd6;
  localparam logic [3:0] S_MUL        = 4'd7;
  localparam logic [3:0] S_PUSH       = 4'd8;
  localparam logic [3:0] S_OUT        = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          state_next    = S_DERIVE;
        end else if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_DERIVE: begin
        cmd.derive_start = 1'b1;
        state_next       = S_DERIVE_DIV;
      end
      S_DERIVE_DIV: begin
        if (sts.div_done) begin
          cmd.derive_finish = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_EVAL: begin
        if (sts.refuse) begin
          cmd.refuse_load = 1'b1;
          state_next      = S_OUT;
        end else if (sts.now_after) begin
          cmd.refill_start = 1'b1;
          state_next       = S_DIV;
        end else begin
          state_next = S_SPEND;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_REFILL;
        end
      end
      S_REFILL: begin
        cmd.refill_finish = 1'b1;
        state_next        = S_SPEND;
      end
      S_SPEND: begin
        cmd.spend  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.multiply = 1'b1;
        state_next   = S_PUSH;
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/smooth_bursty_rate_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smooth_bursty_rate_limiter
// Token-bucket limiter: time-based refill capped at burst times rate, then
// spend of stored permits and push of the next-free time.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_ready    mode, permits, now_us
//   out      out        out_valid/out_ready  granted, wait_us
//
// One request at a time. A request with elapsed time to refill goes through
// the 63-step serial divider, then refill, spend, multiply, push and output;
// without refill it goes straight to spend, a refused try straight to output.
// A configuration write derives the refill interval through the same divider.
// Reset gives rate 1 and burst 1 with an empty bucket; a new beat is taken
// while the last result still waits on a stalled output.
// ----------------------------------------------------------------------------
module smooth_bursty_rate_limiter
  import sbrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [PermitW-1:0]   permits,
  input  logic [TimeW-1:0]     now_us,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 granted,
  output logic [TimeW-1:0]     wait_us
);

  cmd_t cmd;
  sts_t sts;

  sbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbrl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .permits   (permits),
    .now_us    (now_us),
    .granted   (granted),
    .wait_us   (wait_us)
  );

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_no_dual_accept: assert property (@(posedge clk) disable iff (rst)
    !(cfg_valid && cfg_ready && in_valid && in_ready))
    else $error("config and request beat taken together");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready && !cfg_ready)
    else $error("ready right after request beat");

  a_refill_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.refill_finish |-> $past(sts.div_done))
    else $error("refill without finished quotient");
`endif

endmodule

/* dv/tb_smooth_bursty_rate_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smooth_bursty_rate_limiter
// Self-checking bench for the token-bucket limiter. A scoreboard keeps its
// own bucket, next-free time and derived limits, predicts grant and wait for
// every accepted request and compares them with the result beats in order.
// Directed requests open the run, then phases of random traffic under
// different rate and burst settings and handshake pressure, and far-time
// requests that drive the schedule into saturation close it.
// ----------------------------------------------------------------------------
module tb_smooth_bursty_rate_limiter
  import sbrl_pkg::*;
();

  localparam logic                 MODE_BLOCK   = 1'b0;
  localparam logic                 MODE_TRY     = 1'b1;
  localparam logic [CfgIndexW-1:0] REG_SPARE_A  = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_SPARE_B  = 2'd3;
  localparam logic [63:0]          TIME_CEIL    = {1'b0, TIME_MAX};
  localparam int                   PHASES       = 8;
  localparam int                   PHASE_ITEMS  = 200;
  localparam int                   DRAIN_CYCLES = 100;
  localparam int                   CYCLE_LIMIT  = 1500000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_plan_t;

  typedef struct packed {
    logic             granted;
    logic [TimeW-1:0] wait_us;
  } verdict_t;

  class limiter_scoreboard;
    logic [RateW-1:0]  rate_raw;
    logic [BurstW-1:0] burst_raw;
    logic [StoreW-1:0] bucket;
    logic [63:0]       free_at;
    logic [RateW-1:0]  interval;
    logic [StoreW-1:0] bucket_cap;
    verdict_t          pending_verdicts[$];
    int                errors;
    int                matched;
    int                grants;
    int                refusals;

    function new();
      rate_raw  = RateW'(1);
      burst_raw = BurstW'(1);
      bucket    = '0;
      free_at   = '0;
      errors    = 0;
      matched   = 0;
      grants    = 0;
      refusals  = 0;
      update_limits();
    endfunction

    function void update_limits();
      logic [RateW-1:0]  r;
      logic [BurstW-1:0] b;
      r = rate_raw;
      b = burst_raw;
      if (r == '0) r = RateW'(1);
      if (r > RATE_MAX) r = RATE_MAX;
      if (b == '0) b = BurstW'(1);
      if (b > BURST_MAX) b = BURST_MAX;
      interval   = MICROS_PER_SECOND / r;
      bucket_cap = StoreW'(b) * StoreW'(r);
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_RATE: begin
          rate_raw = data[RateW-1:0];
          update_limits();
        end
        REG_BURST: begin
          burst_raw = data[BurstW-1:0];
          update_limits();
        end
        default: ;
      endcase
    endfunction

    // refill from elapsed time, spend stored permits, push the schedule
    function logic [63:0] take_permits(logic [PermitW-1:0] need, logic [63:0] t);
      logic [63:0]       gained;
      logic [63:0]       total;
      logic [63:0]       push;
      logic [63:0]       start;
      logic [StoreW-1:0] spend;
      logic [StoreW-1:0] missing;
      if (t > free_at) begin
        gained = (t - free_at) / 64'(interval);
        total  = 64'(bucket) + gained;
        if (total > 64'(bucket_cap)) total = 64'(bucket_cap);
        bucket  = total[StoreW-1:0];
        free_at = t;
      end
      start   = free_at;
      spend   = (StoreW'(need) < bucket) ? StoreW'(need) : bucket;
      missing = StoreW'(need) - spend;
      push    = 64'(missing) * 64'(interval);
      if (free_at > TIME_CEIL - push) free_at = TIME_CEIL;
      else free_at = free_at + push;
      bucket = bucket - spend;
      return start;
    endfunction

    function void note_request(logic m, logic [PermitW-1:0] need, logic [TimeW-1:0] t);
      logic [63:0] now;
      logic [63:0] start;
      verdict_t    v;
      now = {1'b0, t};
      if (m == MODE_BLOCK) begin
        start     = take_permits(need, now);
        v.granted = 1'b1;
        v.wait_us = (start > now) ? TimeW'(start - now) : '0;
      end else if (now < free_at) begin
        v.granted = 1'b0;
        v.wait_us = TimeW'(free_at - now);
      end else begin
        void'(take_permits(need, now));
        v.granted = 1'b1;
        v.wait_us = '0;
      end
      if (v.granted) grants++;
      else refusals++;
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic g, logic [TimeW-1:0] w);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("result beat with nothing expected: granted=%0d wait_us=%0d", g, w);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        if (g !== v.granted) begin
          $error("granted: expected %0d, actual %0d", v.granted, g);
          errors++;
        end
        if (w !== v.wait_us) begin
          $error("wait_us: expected %0d, actual %0d", v.wait_us, w);
          errors++;
        end
        matched++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 mode      = MODE_BLOCK;
  logic [PermitW-1:0]   permits   = '0;
  logic [TimeW-1:0]     now_us    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 granted;
  logic [TimeW-1:0]     wait_us;

  limiter_scoreboard    sb;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   cycle_count    = 0;
  int                   requests       = 0;
  int                   reg_writes     = 0;
  logic [TimeW-1:0]     clock_us       = '0;

  smooth_bursty_rate_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .permits   (permits),
    .now_us    (now_us),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .granted   (granted),
    .wait_us   (wait_us)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(granted, wait_us);
  end

  function automatic void set_idling(idle_plan_t plan);
    case (plan)
      IDLE_SENDER: begin
        send_idle_pct  = 77;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 77;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 19;
        recv_stall_pct = 19;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic m, input logic [PermitW-1:0] need,
                              input logic [TimeW-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    permits  <= need;
    now_us   <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_request(m, need, t);
    requests++;
  endtask

  // mostly small demand and steps near the refill interval, with rare
  // large demands, long jumps, repeated timestamps and time going back
  task automatic random_request();
    logic               m;
    logic [PermitW-1:0] need;
    logic [TimeW-1:0]   t;
    logic [63:0]        step;
    logic [63:0]        back;
    int                 pick;
    m    = ($urandom_range(99) < 40) ? MODE_TRY : MODE_BLOCK;
    pick = $urandom_range(99);
    if (pick < 70) need = PermitW'($urandom_range(0, 4));
    else if (pick < 94) need = PermitW'($urandom_range(5, 64));
    else if (pick < 97) need = PermitW'($urandom_range(65, 65535));
    else need = pick[0] ? '1 : '0;
    pick = $urandom_range(99);
    if (pick < 5) begin
      back = 64'($urandom_range(1, 3 * sb.interval));
      t    = (back > {1'b0, clock_us}) ? '0 : clock_us - TimeW'(back);
    end else begin
      if (pick < 11) step = '0;
      else if (pick < 15) step = 64'(sb.interval) * 64'($urandom_range(0, 200000));
      else step = 64'(sb.interval) * 64'($urandom_range(0, 6)) +
                  64'($urandom_range(0, sb.interval));
      clock_us = clock_us + TimeW'(step);
      t        = clock_us;
    end
    send_request(m, need, t);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CfgDataW-1:0] phase_rate[PHASES];
    logic [CfgDataW-1:0] phase_burst[PHASES];
    idle_plan_t          phase_plan[PHASES];
    int                  phase_shift[PHASES];
    phase_rate  = '{20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd1, 20'd1000, 20'd1, 20'd1};
    phase_burst = '{20'd1, 20'd3600, 20'd0, 20'hFFFFF, 20'd1, 20'hFF002, 20'd1, 20'd3600};
    phase_rate[4]  = CfgDataW'($urandom_range(1, 1000000));
    phase_burst[4] = CfgDataW'($urandom_range(1, 3600));
    phase_rate[6]  = CfgDataW'($urandom_range(1, 100));
    phase_burst[6] = CfgDataW'($urandom_range(1, 3600));
    phase_rate[7]  = CfgDataW'($urandom_range(1, 1000000));
    phase_plan  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    phase_shift = '{44, 36, 30, 24, 18, 12, 4, 3};

    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: one permit per second, bucket of one
    send_request(MODE_BLOCK, 16'd0, 63'd0);
    send_request(MODE_BLOCK, 16'd1, 63'd0);
    send_request(MODE_TRY, 16'd1, 63'd500000);
    send_request(MODE_BLOCK, 16'd2, 63'd500000);
    send_request(MODE_BLOCK, 16'd1, 63'd100);
    send_request(MODE_TRY, 16'd0, 63'd4000000);
    send_request(MODE_BLOCK, 16'd3, 63'd9000000);
    send_request(MODE_TRY, 16'hFFFF, 63'd10000000);
    send_request(MODE_BLOCK, 16'hFFFF, 63'd20000000);
    send_request(MODE_TRY, 16'd5, 63'd20000000);
    clock_us = 63'd20000000;
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_idling(phase_plan[p]);
      write_reg(REG_RATE, phase_rate[p]);
      write_reg(REG_BURST, phase_burst[p]);
      if (p == 2) write_reg(REG_SPARE_A, CfgDataW'($urandom));
      if (p == 7) write_reg(REG_SPARE_B, CfgDataW'($urandom));
      clock_us = clock_us + TimeW'({$urandom, $urandom} >> phase_shift[p]);
      repeat (PHASE_ITEMS) random_request();
      settle();
    end

    // far end of time: schedule and waits saturate
    set_idling(IDLE_BOTH);
    send_request(MODE_BLOCK, 16'hFFFF, TIME_MAX - 63'd10);
    send_request(MODE_TRY, 16'd0, TIME_MAX - 63'd5);
    send_request(MODE_TRY, 16'd7, TIME_MAX);
    send_request(MODE_BLOCK, 16'd1, TIME_MAX);
    send_request(MODE_BLOCK, 16'd1, 63'd0);
    send_request(MODE_TRY, 16'hFFFF, 63'd1);
    settle();

    $display("%0d requests sent, %0d results checked: %0d granted, %0d refused",
             requests, sb.matched, sb.grants, sb.refusals);
    $display("%0d register writes over %0d rate/burst settings, %0d errors",
             reg_writes, PHASES + 1, sb.errors);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/sbrl_pkg.sv
src/sbrl_div.sv
src/sbrl_dp.sv
src/sbrl_ctrl.sv
src/smooth_bursty_rate_limiter.sv
dv/tb_smooth_bursty_rate_limiter.sv
